>>> rtl/rtt_pkg.sv
// rtt_pkg: shared widths, codes, reset values and structs for the RTT tracker.
// No dependencies; every other file of the tracker uses it.
`default_nettype none

package rtt_pkg;

  localparam int SEQ_W       = 63;
  localparam int TIME_W      = 32;
  localparam int STAMP_W     = 16;
  localparam int FIX_W       = 17;
  localparam int SRTT_MS_W   = 13;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [STAMP_W-1:0]   NO_STAMP    = 16'hFFFF;
  localparam logic [SRTT_MS_W-1:0] SRTT_MS_MAX = 13'h1FFF;

  // initial estimator values in whole milliseconds
  localparam int unsigned SRTT_INIT_MS   = 1000;
  localparam int unsigned RTTVAR_INIT_MS = 500;

  // configuration register reset values
  localparam logic [CFG_W-1:0] MIN_RTO_RST      = 16'd50;
  localparam logic [CFG_W-1:0] MAX_RTO_RST      = 16'd1000;
  localparam logic [CFG_W-1:0] PENALTY_RST      = 16'd500;
  localparam logic [CFG_W-1:0] HOLD_LIMIT_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] SAMPLE_LIMIT_RST = 16'd5000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RTO      = 3'd0,
    CFG_MAX_RTO      = 3'd1,
    CFG_PENALTY      = 3'd2,
    CFG_HOLD_LIMIT   = 3'd3,
    CFG_SAMPLE_LIMIT = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    OP_RECV = 1'b0,
    OP_SEND = 1'b1
  } op_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_rto;
    logic [CFG_W-1:0] max_rto;
    logic [CFG_W-1:0] penalty;
    logic [CFG_W-1:0] hold_limit;
    logic [CFG_W-1:0] sample_limit;
  } rtt_cfg_t;

  // classified word handed from the front to the estimator
  typedef struct packed {
    logic [STAMP_W-1:0] stamp_reply_out;
    logic               in_order;
    logic               sample_ok;
    logic [STAMP_W-1:0] sample;
  } rtt_entry_t;

endpackage

`default_nettype wire

>>> rtl/rtt_in_if.sv
// rtt_in_if: input channel of the RTT tracker (valid/ready plus item fields).
// Depends on rtt_pkg for field widths.
`default_nettype none

interface rtt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [rtt_pkg::TIME_W-1:0]   now_ms;
  logic [rtt_pkg::SEQ_W-1:0]    seq_num;
  logic [rtt_pkg::STAMP_W-1:0]  stamp_in;
  logic [rtt_pkg::STAMP_W-1:0]  stamp_reply_in;
  logic                         congestion_seen;

  modport source (
    output valid, opcode, now_ms, seq_num, stamp_in, stamp_reply_in, congestion_seen,
    input  ready
  );
  modport sink (
    input  valid, opcode, now_ms, seq_num, stamp_in, stamp_reply_in, congestion_seen,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/rtt_out_if.sv
// rtt_out_if: result channel of the RTT tracker (valid/ready plus result fields).
// Depends on rtt_pkg for field widths.
`default_nettype none

interface rtt_out_if;
  logic                           valid;
  logic                           ready;
  logic [rtt_pkg::STAMP_W-1:0]    stamp_reply_out;
  logic                           in_order;
  logic [rtt_pkg::CFG_W-1:0]      timeout_ms;
  logic [rtt_pkg::SRTT_MS_W-1:0]  srtt_ms;

  modport source (
    output valid, stamp_reply_out, in_order, timeout_ms, srtt_ms,
    input  ready
  );
  modport sink (
    input  valid, stamp_reply_out, in_order, timeout_ms, srtt_ms,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/rtt_front.sv
// rtt_front: accepts items, tracks sequence order and the held timestamp,
// and classifies each item into a queue word. Depends on rtt_pkg, rtt_in_if.
`default_nettype none

module rtt_front (
  input  logic                clk,
  input  logic                rst,
  rtt_in_if.sink              req,
  input  rtt_pkg::rtt_cfg_t   cfg,
  input  logic                full,
  output logic                push,
  output rtt_pkg::rtt_entry_t entry
);

  logic [rtt_pkg::SEQ_W-1:0]   expected_seq;
  logic [rtt_pkg::STAMP_W-1:0] held_stamp;
  logic [rtt_pkg::TIME_W-1:0]  held_at;
  logic                        held_valid;

  logic                        accept;
  logic                        is_send;
  logic                        fresh;
  logic                        echo;
  logic [rtt_pkg::TIME_W-1:0]  age;
  logic [rtt_pkg::STAMP_W-1:0] sample;
  logic                        sample_ok;

  // take a word whenever the queue has room
  assign req.ready = !full;
  assign accept    = req.valid && req.ready;
  assign push      = accept;

  // classify the item
  always_comb begin
    is_send   = (req.opcode == rtt_pkg::OP_SEND);
    age       = req.now_ms - held_at;
    echo      = is_send && held_valid && (age < {16'b0, cfg.hold_limit});
    fresh     = !is_send && (req.seq_num >= expected_seq);
    sample    = req.now_ms[rtt_pkg::STAMP_W-1:0] - req.stamp_reply_in;
    sample_ok = fresh && (req.stamp_reply_in != rtt_pkg::NO_STAMP) &&
                (sample < cfg.sample_limit);
    entry.stamp_reply_out = echo ? (held_stamp + age[rtt_pkg::STAMP_W-1:0])
                                 : rtt_pkg::NO_STAMP;
    entry.in_order        = fresh;
    entry.sample_ok       = sample_ok;
    entry.sample          = sample;
  end

  // advance sequence and held-stamp state
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq <= '0;
      held_stamp   <= rtt_pkg::NO_STAMP;
      held_at      <= '0;
      held_valid   <= 1'b0;
    end else if (accept) begin
      if (echo) begin
        held_stamp <= rtt_pkg::NO_STAMP;
        held_at    <= '0;
        held_valid <= 1'b0;
      end
      if (fresh) begin
        expected_seq <= req.seq_num + rtt_pkg::SEQ_W'(1);
        if (req.stamp_in != rtt_pkg::NO_STAMP) begin
          held_stamp <= req.congestion_seen ? (req.stamp_in - cfg.penalty) : req.stamp_in;
          held_at    <= req.now_ms;
          held_valid <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_echo_drops_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && echo) |=> !held_valid)
    else $error("held stamp survived an echo");
`endif

endmodule

`default_nettype wire

>>> rtl/rtt_fifo.sv
// rtt_fifo: short queue of classified words between front and estimator.
// Depends on rtt_pkg.
`default_nettype none

module rtt_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rtt_pkg::rtt_entry_t wdata,
  input  logic                pop,
  output rtt_pkg::rtt_entry_t rdata,
  output logic                full,
  output logic                empty
);

  localparam int DEPTH = rtt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rtt_pkg::rtt_entry_t mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // store words
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // move pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

>>> rtl/rtt_back.sv
// rtt_back: SRTT/RTTVAR estimator stage and registered result stage.
// Depends on rtt_pkg and rtt_out_if.
`default_nettype none

module rtt_back #(
  parameter int FRAC_BITS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  rtt_pkg::rtt_cfg_t   cfg,
  input  logic                empty,
  input  rtt_pkg::rtt_entry_t entry,
  output logic                pop,
  rtt_out_if.source           rsp
);

  localparam int FIX_W = rtt_pkg::FIX_W;
  localparam int RF_W  = rtt_pkg::STAMP_W + FRAC_BITS;
  localparam int SUM_W = RF_W + 4;
  localparam int X_W   = FIX_W + 3;
  localparam int Y_W   = FIX_W + 1;
  localparam int unsigned FIX_MAX_INT    = (1 << FIX_W) - 1;
  localparam int unsigned SRTT_INIT_RAW  = rtt_pkg::SRTT_INIT_MS << FRAC_BITS;
  localparam int unsigned RTTVAR_INIT_RAW = rtt_pkg::RTTVAR_INIT_MS << FRAC_BITS;
  localparam logic [FIX_W-1:0] SRTT_INIT =
    (SRTT_INIT_RAW > FIX_MAX_INT) ? {FIX_W{1'b1}} : FIX_W'(SRTT_INIT_RAW);
  localparam logic [FIX_W-1:0] RTTVAR_INIT =
    (RTTVAR_INIT_RAW > FIX_MAX_INT) ? {FIX_W{1'b1}} : FIX_W'(RTTVAR_INIT_RAW);
  localparam logic [SUM_W-1:0] FIX_MAX   = {{(SUM_W-FIX_W){1'b0}}, {FIX_W{1'b1}}};
  localparam logic [X_W-1:0]   CEIL_ADD  = X_W'((1 << FRAC_BITS) - 1);
  localparam logic [Y_W-1:0]   ROUND_ADD = Y_W'(1 << (FRAC_BITS - 1));

  function automatic logic [FIX_W-1:0] sat_fix(input logic [SUM_W-1:0] v);
    return (v > FIX_MAX) ? {FIX_W{1'b1}} : v[FIX_W-1:0];
  endfunction

  logic [FIX_W-1:0] srtt;
  logic [FIX_W-1:0] rttvar;
  logic             rtt_seen;

  logic                        s1_valid;
  logic [rtt_pkg::STAMP_W-1:0] s1_reply;
  logic                        s1_in_order;

  logic                          out_valid;
  logic [rtt_pkg::STAMP_W-1:0]   out_reply;
  logic                          out_in_order;
  logic [rtt_pkg::CFG_W-1:0]     out_timeout;
  logic [rtt_pkg::SRTT_MS_W-1:0] out_srtt_ms;

  logic                          adv;
  logic [SUM_W-1:0]              rf;
  logic [SUM_W-1:0]              s_ext;
  logic [SUM_W-1:0]              v_ext;
  logic [SUM_W-1:0]              diff;
  logic [SUM_W-1:0]              var_sum;
  logic [SUM_W-1:0]              srtt_sum;
  logic [FIX_W-1:0]              srtt_next;
  logic [FIX_W-1:0]              rttvar_next;
  logic [X_W-1:0]                x;
  logic [X_W-1:0]                rto;
  logic [rtt_pkg::CFG_W-1:0]     timeout_next;
  logic [Y_W-1:0]                y;
  logic [Y_W-1:0]                srtt_round;
  logic [rtt_pkg::SRTT_MS_W-1:0] srtt_ms_next;

  // move the whole back end when the result register is free or taken
  assign adv = !out_valid || rsp.ready;
  assign pop = adv && !empty;

  // estimator update for the word at the queue head
  always_comb begin
    rf       = SUM_W'(entry.sample) << FRAC_BITS;
    s_ext    = SUM_W'(srtt);
    v_ext    = SUM_W'(rttvar);
    diff     = (s_ext > rf) ? (s_ext - rf) : (rf - s_ext);
    var_sum  = (v_ext + (v_ext << 1) + diff + SUM_W'(2)) >> 2;
    srtt_sum = ((s_ext << 3) - s_ext + rf + SUM_W'(4)) >> 3;
    if (!rtt_seen) begin
      srtt_next   = sat_fix(rf);
      rttvar_next = sat_fix(rf >> 1);
    end else begin
      srtt_next   = sat_fix(srtt_sum);
      rttvar_next = sat_fix(var_sum);
    end
  end

  // timeout and rounded SRTT from the state left by the stage-one word
  always_comb begin
    x   = X_W'(srtt) + (X_W'(rttvar) << 2) + CEIL_ADD;
    rto = x >> FRAC_BITS;
    if (rto < X_W'(cfg.min_rto)) begin
      timeout_next = cfg.min_rto;
    end else if (rto > X_W'(cfg.max_rto)) begin
      timeout_next = cfg.max_rto;
    end else begin
      timeout_next = rto[rtt_pkg::CFG_W-1:0];
    end
    y          = Y_W'(srtt) + ROUND_ADD;
    srtt_round = y >> FRAC_BITS;
    srtt_ms_next = (srtt_round > Y_W'(rtt_pkg::SRTT_MS_MAX)) ? rtt_pkg::SRTT_MS_MAX
                                                           : srtt_round[rtt_pkg::SRTT_MS_W-1:0];
  end

  // estimator state
  always_ff @(posedge clk) begin
    if (rst) begin
      srtt     <= SRTT_INIT;
      rttvar   <= RTTVAR_INIT;
      rtt_seen <= 1'b0;
    end else if (pop && entry.sample_ok) begin
      srtt     <= srtt_next;
      rttvar   <= rttvar_next;
      rtt_seen <= 1'b1;
    end
  end

  // stage one and result register valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= pop;
      out_valid <= s1_valid;
    end
  end

  // stage one and result register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_reply     <= entry.stamp_reply_out;
      s1_in_order  <= entry.in_order;
      out_reply    <= s1_reply;
      out_in_order <= s1_in_order;
      out_timeout  <= timeout_next;
      out_srtt_ms  <= srtt_ms_next;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.stamp_reply_out = out_reply;
  assign rsp.in_order        = out_in_order;
  assign rsp.timeout_ms      = out_timeout;
  assign rsp.srtt_ms         = out_srtt_ms;

`ifndef ASSERT_OFF
  a_seen_sticks: assert property (@(posedge clk) disable iff (rst) rtt_seen |=> rtt_seen)
    else $error("first-sample flag cleared");
  a_srtt_idle_init: assert property (@(posedge clk) disable iff (rst)
    !rtt_seen |-> (srtt == SRTT_INIT && rttvar == RTTVAR_INIT))
    else $error("estimator moved before first sample");
`endif

endmodule

`default_nettype wire

>>> rtl/rtt_timestamp_tracker.sv
// Each accepted item passes the queue, stage one and the result register.
// Throughput: one item per cycle while rsp.ready holds; estimator and result
// register each advance once per cycle; a two-word queue decouples the front end.
// Reset (synchronous, rst high) clears all but queue and stage data; no clearing pass.
// Holds the configuration registers and joins front, queue and estimator.
`default_nettype none

module rtt_timestamp_tracker #(
  parameter int FRAC_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  rtt_in_if.sink                          req,
  rtt_out_if.source                       rsp,
  input  logic                            cfg_wr_en,
  input  logic [rtt_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [rtt_pkg::CFG_W-1:0]       cfg_wdata
);

  rtt_pkg::rtt_cfg_t   cfg;
  rtt_pkg::rtt_entry_t push_word;
  rtt_pkg::rtt_entry_t head_word;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_rto      <= rtt_pkg::MIN_RTO_RST;
      cfg.max_rto      <= rtt_pkg::MAX_RTO_RST;
      cfg.penalty      <= rtt_pkg::PENALTY_RST;
      cfg.hold_limit   <= rtt_pkg::HOLD_LIMIT_RST;
      cfg.sample_limit <= rtt_pkg::SAMPLE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        rtt_pkg::CFG_MIN_RTO:      cfg.min_rto      <= cfg_wdata;
        rtt_pkg::CFG_MAX_RTO:      cfg.max_rto      <= cfg_wdata;
        rtt_pkg::CFG_PENALTY:      cfg.penalty      <= cfg_wdata;
        rtt_pkg::CFG_HOLD_LIMIT:   cfg.hold_limit   <= cfg_wdata;
        rtt_pkg::CFG_SAMPLE_LIMIT: cfg.sample_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rtt_front u_front (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .cfg   (cfg),
    .full  (full),
    .push  (push),
    .entry (push_word)
  );

  rtt_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_word),
    .pop   (pop),
    .rdata (head_word),
    .full  (full),
    .empty (empty)
  );

  rtt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .empty (empty),
    .entry (head_word),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

`default_nettype wire
